### sv/first_fit_heap_allocator_defines.svh
// Assertion helpers for the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/ffha_pkg.sv
package ffha_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int HEAP_BYTES_DEF    = 32768;

	localparam logic [15:0] HEAP_LIMIT_RST = 16'd32768;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SPACE  = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_ZERO      = 3'd4;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_SPLIT,
		OP_REMOVE
	} op_t;

	typedef struct packed {
		logic [14:0] start;
		logic [15:0] size;
		logic        used;
	} entry_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] size;
		logic [14:0] addr;
	} key_t;

	// table update broadcast to every cell
	typedef struct packed {
		op_t    op;
		entry_t a;
		entry_t b;
	} cmd_t;

	// search token walking down the chain
	typedef struct packed {
		logic   active;
		logic   found;
		logic   nxt_got;
		entry_t prev;
		entry_t cur;
		entry_t nxt;
	} tok_t;

endpackage

### sv/ffha_cell.sv
module ffha_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::cmd_t      cmd,
	input  logic [IDX_W-1:0]    cmd_k,
	input  ffha_pkg::key_t      key,
	input  logic [CNT_W-1:0]    count,
	input  ffha_pkg::entry_t    left,
	input  ffha_pkg::entry_t    right,
	output ffha_pkg::entry_t    ent,
	input  ffha_pkg::tok_t      tok_in,
	input  logic [IDX_W-1:0]    tok_idx_in,
	output ffha_pkg::tok_t      tok_out,
	output logic [IDX_W-1:0]    tok_idx_out
);
	import ffha_pkg::*;

	localparam logic [IDX_W:0]   MY   = (IDX_W+1)'(IDX);
	localparam logic [CNT_W-1:0] MY_C = CNT_W'(IDX);

	entry_t           ent_q, ent_d;
	tok_t             tok_q, tok_d;
	logic [IDX_W-1:0] tok_idx_q, tok_idx_d;
	logic [IDX_W:0]   kx;
	logic             valid, hit;

	assign kx    = {1'b0, cmd_k};
	assign valid = MY_C < count;
	assign hit   = (key.mode == MODE_ALLOC) ? (!ent_q.used && ent_q.size >= key.size)
	                                        : (ent_q.start == key.addr);

	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			OP_WRITE: begin
				if (MY == kx) ent_d = cmd.a;
			end
			OP_SPLIT: begin
				if (MY == kx) ent_d = cmd.a;
				else if (MY == kx + 1'b1) ent_d = cmd.b;
				else if (MY > kx) ent_d = left;
			end
			OP_REMOVE: begin
				if (MY >= kx) ent_d = right;
			end
			default: ;
		endcase
	end

	always_comb begin
		tok_d     = tok_in;
		tok_idx_d = tok_idx_in;
		if (tok_in.active && valid) begin
			if (!tok_in.found) begin
				if (hit) begin
					tok_d.found = 1'b1;
					tok_d.cur   = ent_q;
					tok_idx_d   = IDX_W'(IDX);
				end else begin
					tok_d.prev = ent_q;
				end
			end else if (!tok_in.nxt_got) begin
				tok_d.nxt_got = 1'b1;
				tok_d.nxt     = ent_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q     <= ent_d;
		tok_idx_q <= tok_idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign ent         = ent_q;
	assign tok_out     = tok_q;
	assign tok_idx_out = tok_idx_q;

endmodule

### sv/first_fit_heap_allocator.sv
// First-fit heap allocator with split and coalesce. The chunk table lives in a
// row of TABLE_ENTRIES cells, one chunk per cell, kept in address order. Each
// transaction sends a search token from cell 0 to the last cell, one cell per
// cycle, collecting the first matching chunk and its two neighbors; the
// controller then issues up to four table updates (write, split-insert or
// remove; split-insert and remove shift entries between neighboring cells).
// A zero-size allocate skips the token walk. A finished result moves into
// its own output register, so the next input is accepted once the
// controller is idle even while that result still waits on out_stall; a
// second finished result waits in the controller and holds in_stall high.
// heap_limit (cfg_we/cfg_wdata) must be written only while idle; the block
// does not enforce this. Values above HEAP_BYTES act as HEAP_BYTES.
module first_fit_heap_allocator #(
	parameter int TABLE_ENTRIES = ffha_pkg::TABLE_ENTRIES_DEF,
	parameter int HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] request_size,
	input  logic [14:0] free_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] block_address,
	output logic [2:0]  status
);
	import ffha_pkg::*;
	`include "first_fit_heap_allocator_defines.svh"

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
	localparam logic [16:0]      HEAP_MAX = 17'(HEAP_BYTES);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_FREE2  = 7'b0001000,
		S_FREE3  = 7'b0010000,
		S_FREE4  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [15:0]      heap_limit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0]      top_q;
	key_t             key_q;
	logic             inj_q;
	tok_t             res_q;
	logic [IDX_W-1:0] res_idx_q;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] cmd_k_q;
	logic [15:0]      newsz_q;
	logic             merge_n_q;
	logic             out_valid_q;
	logic [14:0]      addr_q;
	logic [2:0]       stat_q;
	logic [14:0]      out_addr_q;
	logic [2:0]       out_stat_q;

	entry_t           ent  [TABLE_ENTRIES];
	tok_t             tok  [TABLE_ENTRIES];
	logic [IDX_W-1:0] tidx [TABLE_ENTRIES];
	tok_t             inj_tok;

	logic        in_acc;
	logic        full;
	logic [16:0] limit;
	logic [16:0] bump_end;
	logic [15:0] free_sz;
	tok_t        tail;

	function automatic logic merge_n_c();
		return res_q.nxt_got && !res_q.nxt.used;
	endfunction

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign full     = (cnt_q == FULL_CNT);
	assign limit    = ({1'b0, heap_limit_q} > HEAP_MAX) ? HEAP_MAX : {1'b0, heap_limit_q};
	assign bump_end = top_q + {1'b0, key_q.size};
	assign free_sz  = res_q.cur.size + (merge_n_c() ? res_q.nxt.size : 16'd0);
	assign tail     = tok[TABLE_ENTRIES-1];

	always_comb begin
		inj_tok        = '0;
		inj_tok.active = inj_q;
	end

	// cell row: each cell sees its neighbors for shifting and the token from the left
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		ffha_cell #(
			.IDX   (g),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd_q),
			.cmd_k       (cmd_k_q),
			.key         (key_q),
			.count       (cnt_q),
			.left        ((g == 0) ? ent[0] : ent[(g == 0) ? 0 : g-1]),
			.right       ((g == TABLE_ENTRIES-1) ? ent[g]
			                                     : ent[(g == TABLE_ENTRIES-1) ? g : g+1]),
			.ent         (ent[g]),
			.tok_in      ((g == 0) ? inj_tok : tok[(g == 0) ? 0 : g-1]),
			.tok_idx_in  ((g == 0) ? '0 : tidx[(g == 0) ? 0 : g-1]),
			.tok_out     (tok[g]),
			.tok_idx_out (tidx[g])
		);
	end

	// search result and transaction payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q.mode <= mode;
			key_q.size <= request_size;
			key_q.addr <= free_address;
		end
		if (state_q == S_SCAN && tail.active) begin
			res_q     <= tail;
			res_idx_q <= tidx[TABLE_ENTRIES-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_limit_q <= HEAP_LIMIT_RST;
			cnt_q        <= '0;
			top_q        <= '0;
			inj_q        <= 1'b0;
			cmd_q        <= '0;
			cmd_k_q      <= '0;
			newsz_q      <= '0;
			merge_n_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			addr_q       <= '0;
			stat_q       <= ST_OK;
			out_addr_q   <= '0;
			out_stat_q   <= ST_OK;
		end else begin
			inj_q    <= 1'b0;
			cmd_q.op <= OP_NOP;
			if (cfg_we) heap_limit_q <= cfg_wdata;

			// output register: load a finished result once the previous one is gone
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				out_addr_q  <= addr_q;
				out_stat_q  <= stat_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						addr_q <= '0;
						if (mode == MODE_ALLOC && request_size == 16'd0) begin
							stat_q  <= ST_ZERO;
							state_q <= S_DONE;
						end else begin
							stat_q  <= ST_OK;
							inj_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tail.active) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_DONE;
					if (key_q.mode == MODE_ALLOC) begin
						if (res_q.found) begin
							if (res_q.cur.size == key_q.size) begin
								cmd_q.op   <= OP_WRITE;
								cmd_q.a    <= '{start: res_q.cur.start, size: res_q.cur.size,
								                used: 1'b1};
								cmd_k_q    <= res_idx_q;
								addr_q     <= res_q.cur.start;
							end else if (full) begin
								stat_q <= ST_FULL;
							end else begin
								// split: used front part, free remainder right after it
								cmd_q.op <= OP_SPLIT;
								cmd_q.a  <= '{start: res_q.cur.start, size: key_q.size,
								              used: 1'b1};
								cmd_q.b  <= '{start: res_q.cur.start + key_q.size[14:0],
								              size: res_q.cur.size - key_q.size, used: 1'b0};
								cmd_k_q  <= res_idx_q;
								cnt_q    <= cnt_q + 1'b1;
								addr_q   <= res_q.cur.start;
							end
						end else if (bump_end > limit) begin
							stat_q <= ST_NO_SPACE;
						end else if (full) begin
							stat_q <= ST_FULL;
						end else begin
							// bump allocation appended at the end of the table
							cmd_q.op <= OP_WRITE;
							cmd_q.a  <= '{start: top_q[14:0], size: key_q.size, used: 1'b1};
							cmd_k_q  <= cnt_q[IDX_W-1:0];
							cnt_q    <= cnt_q + 1'b1;
							top_q    <= bump_end;
							addr_q   <= top_q[14:0];
						end
					end else if (!res_q.found) begin
						stat_q <= ST_NOT_FOUND;
					end else begin
						cmd_q.op  <= OP_WRITE;
						cmd_q.a   <= '{start: res_q.cur.start, size: free_sz, used: 1'b0};
						cmd_k_q   <= res_idx_q;
						newsz_q   <= free_sz;
						merge_n_q <= merge_n_c();
						state_q   <= S_FREE2;
					end
				end
				S_FREE2: begin
					// drop the successor absorbed into this chunk
					if (merge_n_q) begin
						cmd_q.op <= OP_REMOVE;
						cmd_k_q  <= res_idx_q + 1'b1;
						cnt_q    <= cnt_q - 1'b1;
					end
					state_q <= S_FREE3;
				end
				S_FREE3: begin
					// fold into a free predecessor
					if (res_idx_q != '0 && !res_q.prev.used) begin
						cmd_q.op <= OP_WRITE;
						cmd_q.a  <= '{start: res_q.prev.start, size: res_q.prev.size + newsz_q,
						              used: 1'b0};
						cmd_k_q  <= res_idx_q - 1'b1;
						state_q  <= S_FREE4;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FREE4: begin
					cmd_q.op <= OP_REMOVE;
					cmd_k_q  <= res_idx_q;
					cnt_q    <= cnt_q - 1'b1;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					// wait here while the output register still holds an unread result
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign block_address = out_addr_q;
	assign status        = out_stat_q;

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= FULL_CNT)
	`ASSERT_ALWAYS(a_top_bound, clk, arst_n, top_q <= HEAP_MAX)
	`ASSERT_IMPLIES(a_tail_in_scan, clk, arst_n, tail.active, state_q == S_SCAN)
	`ASSERT_IMPLIES(a_err_no_addr, clk, arst_n, out_valid_q && out_stat_q != ST_OK, out_addr_q == '0)
	`ASSERT_IMPLIES(a_inj_once, clk, arst_n, inj_q, state_q == S_SCAN && !tok[0].active)

endmodule

### tb/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the first-fit heap allocator.
// A behavioral copy of the chunk table runs beside the block: every accepted
// request is applied to it and the answer it gives is queued; the result
// monitor pops and compares one answer per result transaction.
module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int CHUNKS    = TABLE_ENTRIES_DEF;
	localparam int HEAP_MAX  = HEAP_BYTES_DEF;
	localparam int SETTLE    = 2 * CHUNKS + 20;	// longer than the worst-case latency
	localparam int HOLD_LONG = 600;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [15:0] request_size;
	logic [14:0] free_address;
	logic        out_valid;
	logic        out_stall;
	logic [14:0] block_address;
	logic [2:0]  status;

	first_fit_heap_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.request_size (request_size),
		.free_address (free_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.block_address(block_address),
		.status       (status)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow copy of the allocator state
	// ---------------------------------------------------------------
	int  shadow_start [CHUNKS];
	int  shadow_size  [CHUNKS];
	bit  shadow_used  [CHUNKS];
	int  shadow_count;
	int  shadow_top;
	int  shadow_limit;

	typedef struct packed {
		logic [14:0] addr;
		logic [2:0]  st;
	} answer_t;

	answer_t pending_answers[$];

	int  fail_count;
	int  sent_count;
	int  result_count;
	int  status_seen [5];

	// idle control: no_idle is shared by both sides, hold_req/hold_left drive the result side
	bit  no_idle;
	bit  hold_req;
	int  hold_left;

	// drop entry k, closing the gap
	function automatic void shadow_remove(input int k);
		for (int j = k; j + 1 < shadow_count; j++) begin
			shadow_start[j] = shadow_start[j + 1];
			shadow_size[j]  = shadow_size[j + 1];
			shadow_used[j]  = shadow_used[j + 1];
		end
		shadow_count--;
	endfunction

	function automatic logic [2:0] shadow_alloc(input int sz, output int addr);
		int lim;
		addr = 0;
		if (sz == 0)
			return ST_ZERO;
		// first fit over the table
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_used[i] || shadow_size[i] < sz)
				continue;
			if (shadow_size[i] == sz) begin
				shadow_used[i] = 1'b1;
				addr = shadow_start[i];
				return ST_OK;
			end
			// split needs a spare slot; no further search if none
			if (shadow_count >= CHUNKS)
				return ST_FULL;
			for (int j = shadow_count; j > i + 1; j--) begin
				shadow_start[j] = shadow_start[j - 1];
				shadow_size[j]  = shadow_size[j - 1];
				shadow_used[j]  = shadow_used[j - 1];
			end
			shadow_start[i + 1] = shadow_start[i] + sz;
			shadow_size[i + 1]  = shadow_size[i] - sz;
			shadow_used[i + 1]  = 1'b0;
			shadow_size[i]      = sz;
			shadow_used[i]      = 1'b1;
			shadow_count++;
			addr = shadow_start[i];
			return ST_OK;
		end
		// nothing fits: carve from the bump pointer
		lim = (shadow_limit > HEAP_MAX) ? HEAP_MAX : shadow_limit;
		if (shadow_top + sz > lim)
			return ST_NO_SPACE;
		if (shadow_count >= CHUNKS)
			return ST_FULL;
		shadow_start[shadow_count] = shadow_top;
		shadow_size[shadow_count]  = sz;
		shadow_used[shadow_count]  = 1'b1;
		shadow_count++;
		addr = shadow_top;
		shadow_top += sz;
		return ST_OK;
	endfunction

	function automatic logic [2:0] shadow_free(input int fa);
		int i;
		for (i = 0; i < shadow_count; i++)
			if (shadow_start[i] == fa)
				break;
		if (i >= shadow_count)
			return ST_NOT_FOUND;
		shadow_used[i] = 1'b0;
		// merge with successor, then predecessor
		if (i + 1 < shadow_count && !shadow_used[i + 1]) begin
			shadow_size[i] += shadow_size[i + 1];
			shadow_remove(i + 1);
		end
		if (i > 0 && !shadow_used[i - 1]) begin
			shadow_size[i - 1] += shadow_size[i];
			shadow_remove(i);
		end
		return ST_OK;
	endfunction

	function automatic answer_t apply_request(input logic m, input logic [15:0] sz,
			input logic [14:0] fa);
		answer_t r;
		int a;
		a = 0;
		if (m == MODE_ALLOC)
			r.st = shadow_alloc(int'(sz), a);
		else
			r.st = shadow_free(int'(fa));
		r.addr = a[14:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// Offers one request; returns in the step of its acceptance so that the
	// next call can keep in_valid high without a second assignment.
	task automatic send_request(input logic m, input logic [15:0] sz, input logic [14:0] fa);
		int gap;
		bit taken;
		gap = (!no_idle && $urandom_range(99) < 36) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		request_size <= sz;
		free_address <= fa;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pending_answers.push_back(apply_request(m, sz, fa));
		sent_count++;
	endtask

	task automatic alloc_req(input int sz);
		send_request(MODE_ALLOC, sz[15:0], 15'($urandom));
	endtask

	task automatic free_req(input int fa);
		send_request(MODE_FREE, 16'($urandom), fa[14:0]);
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_heap_limit(input logic [15:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_limit = int'(v);
	endtask

	// ---------------------------------------------------------------
	// Result side: stall generator and checker
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_req) begin
				hold_left = HOLD_LONG;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 36);
			end
		end
	end

	// Sampled mid-cycle: outputs and out_stall are settled for the coming edge.
	always @(negedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_answers.size() == 0) begin
				$error("unexpected result: block_address %0d status %0d",
					block_address, status);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (status <= ST_ZERO)
					status_seen[status]++;
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
				if (block_address !== want.addr) begin
					$error("block_address: expected %0d, got %0d",
						want.addr, block_address);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// corner cases of alloc/free on a fresh heap
	task automatic test_directed;
		alloc_req(0);           // zero size
		alloc_req(100);         // bump at 0
		alloc_req(200);         // bump at 100
		free_req(32767);        // unknown address, all ones
		free_req(0);            // free, successor used
		free_req(0);            // free of an already free chunk
		free_req(100);          // merges into the chunk at 0
		free_req(100);          // start merged away: not found
		alloc_req(300);         // exact fit of the merged chunk
		free_req(0);
		alloc_req(120);         // split
		alloc_req(180);         // exact fit of the remainder
		free_req(120);          // lone free chunk after a used one
		free_req(0);            // merges with successor
		alloc_req(32768);       // larger than anything left
		alloc_req(50);          // split of the first free chunk
		free_req(50);
		free_req(0);
		free_req(120);          // no chunk starts here: not found
		drain();
	endtask

	// fill all table slots, then hit the full-table cases on both paths
	task automatic test_table_full;
		set_heap_limit(16'hFFFF);   // above the heap size, acts as the heap size
		while (shadow_count < CHUNKS)
			alloc_req(3);
		alloc_req(200);             // bump with full table
		free_req(shadow_start[10]);
		alloc_req(1);               // split with full table
		alloc_req(3);               // exact fit still works
		for (int k = CHUNKS - 1; k >= 0; k -= 2)
			free_req(shadow_start[k]);
		// free the used chunk at the front so every step merges something
		while (shadow_count > 1)
			free_req(shadow_start[shadow_used[1] ? 1 : 0]);
		free_req(shadow_start[0]);
		drain();
	endtask

	// one random request, mostly well-formed: frees of live chunks and small sizes
	task automatic random_request;
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick < 45 && shadow_count > 0) begin
			k = $urandom_range(shadow_count - 1);
			free_req(shadow_start[k]);
		end else if (pick < 52) begin
			free_req($urandom_range(32767));
		end else if (pick < 60 && shadow_count > 0) begin
			k = $urandom_range(shadow_count - 1);
			alloc_req(shadow_size[k]);
		end else if (pick < 63) begin
			alloc_req($urandom_range(32768));
		end else if (pick < 64) begin
			alloc_req(0);
		end else begin
			alloc_req($urandom_range(1, 400));
		end
	endtask

	task automatic test_random(input int n, input logic [15:0] lim, input bit quiet);
		set_heap_limit(lim);
		no_idle = quiet;
		repeat (n) random_request();
		drain();
		no_idle = 1'b0;
	endtask

	// long receiver hold-off while requests keep coming, then a full pause
	task automatic test_backpressure;
		hold_req = 1'b1;
		repeat (12) random_request();
		drain();
		repeat (20) random_request();
		drain();
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		mode         = MODE_ALLOC;
		request_size = '0;
		free_address = '0;
		no_idle      = 1'b0;
		hold_req     = 1'b0;
		fail_count   = 0;
		sent_count   = 0;
		result_count = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		shadow_count = 0;
		shadow_top   = 0;
		shadow_limit = int'(HEAP_LIMIT_RST);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_random(350, 16'd32768, 1'b0);
		test_backpressure();
		test_random(250, 16'd20000, 1'b1);    // no idling on either side
		test_random(250, 16'd0, 1'b0);        // bump always out of space
		test_random(300, 16'hFFFF, 1'b0);
		test_random(300, 16'd2500, 1'b0);     // limit below the bump pointer
		test_random(100, 16'd32768, 1'b0);
		drain();

		$display("%0d requests, %0d results; ok %0d, no space %0d, full %0d,",
			sent_count, result_count, status_seen[0], status_seen[1], status_seen[2]);
		$display("not found %0d, zero size %0d; heap limits 0 to 65535 exercised",
			status_seen[3], status_seen[4]);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_cell.sv
sv/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
